/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define RLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RLM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RLM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

/* rtl/rlm_pkg.sv */
// Package: constants, codes, coefficient and log table functions of the magnitude unit.
package rlm_pkg;

	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int KM_PER_DEG_Q16     = 7287276;
	localparam int LOG10_2_Q28        = 80807124;
	localparam logic [15:0] MIN_SNR_RST = 16'd512;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_AMP    = 2'd1;
	localparam logic [1:0] ST_REGION = 2'd2;
	localparam logic [1:0] ST_SNR    = 2'd3;

	localparam logic [1:0] REG_NONE  = 2'd0;
	localparam logic [1:0] REG_WEST  = 2'd1;
	localparam logic [1:0] REG_EAST  = 2'd2;
	localparam logic [1:0] REG_SOUTH = 2'd3;

	typedef struct packed {
		logic        valid;
		logic [1:0]  status;
		logic        keep;
		logic [1:0]  region;
		logic [31:0] amp;
	} side_t;

	// distance slope coefficient, Q.28
	function automatic logic signed [29:0] coef_a(input logic [1:0] rg);
		case (rg)
			REG_WEST:  coef_a = 30'sd305211113;
			REG_EAST:  coef_a = 30'sd359703511;
			REG_SOUTH: coef_a = 30'sd295279002;
			default:   coef_a = 30'sd0;
		endcase
	endfunction

	// attenuation coefficient, Q.40
	function automatic logic signed [31:0] coef_b(input logic [1:0] rg);
		case (rg)
			REG_WEST:  coef_b = 32'sd722379139;
			REG_EAST:  coef_b = 32'sd604731395;
			REG_SOUTH: coef_b = 32'sd1429365116;
			default:   coef_b = 32'sd0;
		endcase
	endfunction

	// offset, Q.28
	function automatic logic signed [30:0] coef_c(input logic [1:0] rg);
		case (rg)
			REG_WEST:  coef_c = 31'sd177167401;
			REG_EAST:  coef_c = 31'sd840202977;
			REG_SOUTH: coef_c = 31'sd187904819;
			default:   coef_c = 31'sd0;
		endcase
	endfunction

	// log2(1 + i/2^ltb) in Q1.28 by repeated squaring; elaborated with constant arguments
	function automatic logic [28:0] log_entry(input int unsigned i, input int unsigned ltb);
		logic [63:0] x;
		logic [28:0] frac;
		int unsigned tab;
		tab  = 32'd1 << ltb;
		frac = '0;
		x    = 64'(tab + i) << (30 - ltb);
		for (int k = 27; k >= 0; k--) begin
			x = (x * x) >> 30;
			if (x >= (64'd2 << 30)) begin
				x       = x >> 1;
				frac[k] = 1'b1;
			end
		end
		if (i >= tab) begin
			frac = 29'd1 << 28;
		end
		return frac;
	endfunction

endpackage

/* rtl/rlm_log10.sv */
// Six-stage pipelined log10 of a Q.16 value, result in Q.28.
module rlm_log10 import rlm_pkg::*; #(
	parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic [31:0]        v,
	output logic signed [33:0] l10
);
	localparam int TAB_N = 1 << LOG_TABLE_BITS;
	localparam int RB    = 31 - LOG_TABLE_BITS;
	localparam logic signed [28:0] C10 = 29'(LOG10_2_Q28);

	logic [28:0] rom [0:TAB_N];
	for (genvar g = 0; g <= TAB_N; g++) begin : g_rom
		assign rom[g] = log_entry(g, LOG_TABLE_BITS);
	end

	logic [31:0] v_l1;
	logic [4:0]  p_l1, p_l2, p_l3, p_c;
	logic [28:0] lo_l2, df_l2, lo_l3, prod_l3;
	logic [RB-1:0] rem_l2;
	logic signed [33:0] l2_l4;
	logic signed [46:0] pph_l5, ppl_l5;
	logic [31:0] m;
	logic [LOG_TABLE_BITS-1:0] idx;
	logic [LOG_TABLE_BITS:0] idx1;
	logic [57:0] prd;
	logic signed [33:0] l2;
	logic signed [63:0] sum;

	// leading one position
	always_comb begin
		p_c = '0;
		for (int b = 0; b < 32; b++) begin
			if (v[b]) p_c = 5'(b);
		end
	end

	assign m    = v_l1 << (5'd31 - p_l1);
	assign idx  = m[30:RB];
	assign idx1 = {1'b0, idx} + 1'b1;
	assign prd  = 58'(df_l2) * 58'(rem_l2);
	assign l2   = ((34'($signed({1'b0, p_l3})) - 34'sd16) <<< 28)
		+ 34'(lo_l3) + 34'(prod_l3);
	assign sum  = (64'(pph_l5) <<< 17) + 64'(ppl_l5);

	always_ff @(posedge clk) begin
		v_l1    <= v;
		p_l1    <= p_c;
		p_l2    <= p_l1;
		lo_l2   <= rom[idx];
		df_l2   <= rom[idx1] - rom[idx];
		rem_l2  <= m[RB-1:0];
		p_l3    <= p_l2;
		lo_l3   <= lo_l2;
		prod_l3 <= 29'(prd >> RB);
		l2_l4   <= l2;
		// upper half keeps the sign of the log2 value
		pph_l5  <= 47'($signed(l2_l4[33:17]) * C10);
		ppl_l5  <= 47'($signed({1'b0, l2_l4[16:0]}) * C10);
		l10     <= 34'(sum >>> 28);
	end
endmodule

/* rtl/regional_local_magnitude_unit.sv */
// Regional local magnitude unit: deep pipeline from station reading to magnitude.
// Throughput: one item per cycle; busy stays low, the square root (two bits per
// stage over sixteen stages) and the two log10 pipelines set the depth.
// Reset (arst_n low, asynchronous) empties the pipeline and sets min_snr to 2.0.
// The receiver cannot stall: each result shows for one cycle with done high.
`include "assert_macros.svh"
module regional_local_magnitude_unit import rlm_pkg::*; #(
	parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [31:0]        amp_mm,
	input  logic [23:0]        dist_deg,
	input  logic [15:0]        depth_km,
	input  logic [1:0]         region,
	input  logic [15:0]        snr_in,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	output logic               done,
	output logic signed [19:0] magnitude,
	output logic [1:0]         status,
	output logic               keep_flag
);
	localparam int SB_DEPTH = 27;
	localparam int LATENCY  = 28;
	localparam int SQ_STG   = 16;
	localparam logic signed [33:0] TWO_Q28     = 34'sd536870912;
	localparam logic signed [32:0] HUNDRED_Q16 = 33'sd6553600;

	logic [15:0] min_snr_q;
	logic        accept;
	side_t       sb [0:SB_DEPTH-1];
	side_t       sb_in;

	// Nothing in the pipe ever holds an item back.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_snr_q <= MIN_SNR_RST;
		end else if (cfg_we) begin
			min_snr_q <= cfg_wdata;
		end
	end

	// Status is settled on entry: amplitude first, then region, then SNR.
	always_comb begin
		sb_in.valid  = accept;
		sb_in.region = region;
		sb_in.amp    = amp_mm;
		sb_in.keep   = 1'b0;
		if (amp_mm == 32'd0) begin
			sb_in.status = ST_AMP;
		end else if (region == REG_NONE) begin
			sb_in.status = ST_REGION;
		end else if (snr_in < min_snr_q) begin
			sb_in.status = ST_SNR;
			sb_in.keep   = 1'b1;
		end else begin
			sb_in.status = ST_OK;
		end
	end

	// Side band travels alongside the data, one slot per register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SB_DEPTH; k++) sb[k] <= '0;
		end else begin
			sb[0] <= sb_in;
			for (int k = 1; k < SB_DEPTH; k++) sb[k] <= sb[k-1];
		end
	end

	// Stages 1 to 3: horizontal km, squares, sum of squares (all Q.16 / Q.32).
	logic [30:0] hkm_s1;
	logic [25:0] dkm_s1;
	logic [61:0] hsq_s2;
	logic [51:0] dsq_s2;
	logic [62:0] sum_s3;
	logic [47:0] hprod;

	assign hprod = 48'(dist_deg) * 48'(KM_PER_DEG_Q16) + 48'd32768;

	always_ff @(posedge clk) begin
		hkm_s1 <= hprod[46:16];
		dkm_s1 <= {depth_km, 10'd0};
		hsq_s2 <= 62'(hkm_s1) * 62'(hkm_s1);
		dsq_s2 <= 52'(dkm_s1) * 52'(dkm_s1);
		sum_s3 <= 63'(hsq_s2) + 63'(dsq_s2);
	end

	// Stages 4 to 19: restoring square root, two result bits per stage.
	logic [63:0] sq_rem_s  [0:SQ_STG];
	logic [31:0] sq_root_s [0:SQ_STG];

	assign sq_rem_s[0]  = {1'b0, sum_s3};
	assign sq_root_s[0] = '0;

	for (genvar j = 0; j < SQ_STG; j++) begin : g_sq
		logic [63:0] rem_n;
		logic [31:0] root_n;
		logic [63:0] trial;
		always_comb begin
			rem_n  = sq_rem_s[j];
			root_n = sq_root_s[j];
			trial  = '0;
			for (int b = 0; b < 2; b++) begin
				trial = ({32'd0, root_n} << (32 - 2*j - b))
					| (64'd1 << (2 * (31 - 2*j - b)));
				if (rem_n >= trial) begin
					rem_n  = rem_n - trial;
					root_n = root_n | (32'd1 << (31 - 2*j - b));
				end
			end
		end
		always_ff @(posedge clk) begin
			sq_rem_s[j+1]  <= rem_n;
			sq_root_s[j+1] <= root_n;
		end
	end

	// A zero distance counts as one LSB.
	logic [31:0] r_c;
	assign r_c = (sq_root_s[SQ_STG] == 32'd0) ? 32'd1 : sq_root_s[SQ_STG];

	// Stages 20 to 25: both logarithms side by side; hold r alongside.
	logic signed [33:0] l10_r, l10_a;
	logic [31:0] r_dl [0:5];

	rlm_log10 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_r (
		.clk (clk), .v (r_c), .l10 (l10_r)
	);
	rlm_log10 #(.LOG_TABLE_BITS(LOG_TABLE_BITS)) u_log_a (
		.clk (clk), .v (sb[18].amp), .l10 (l10_a)
	);

	always_ff @(posedge clk) begin
		r_dl[0] <= r_c;
		for (int k = 1; k < 6; k++) r_dl[k] <= r_dl[k-1];
	end

	// Stage 26: region terms. East works on log10(r) - 2 and r - 100 km.
	logic signed [31:0] lr_c;
	logic signed [32:0] dr_c;
	logic signed [61:0] pa_s26;
	logic signed [64:0] pb_s26;
	logic signed [33:0] la_s26;
	logic signed [30:0] c_s26;
	logic               east;

	assign east = (sb[24].region == REG_EAST);
	assign lr_c = 32'(east ? (l10_r - TWO_Q28) : l10_r);
	assign dr_c = east ? ($signed({1'b0, r_dl[5]}) - HUNDRED_Q16) : $signed({1'b0, r_dl[5]});

	always_ff @(posedge clk) begin
		pa_s26 <= 62'(lr_c * coef_a(sb[24].region));
		pb_s26 <= 65'(dr_c * coef_b(sb[24].region));
		la_s26 <= l10_a;
		c_s26  <= coef_c(sb[24].region);
	end

	// Stage 27: floor the products to Q.28 and sum.
	logic signed [39:0] acc_s27;
	always_ff @(posedge clk) begin
		acc_s27 <= 40'(la_s26) + 40'(pa_s26 >>> 28) + 40'(pb_s26 >>> 28) + 40'(c_s26);
	end

	// Stage 28: round half up to Q.12, saturate, drop the value on rejected items.
	logic signed [23:0] rnd;
	logic signed [19:0] mag_c;
	logic               done_q;
	logic signed [19:0] magnitude_q;
	logic [1:0]         status_q;
	logic               keep_q;

	assign rnd = 24'((acc_s27 + 40'sd32768) >>> 16);

	always_comb begin
		if (rnd > 24'sd524287) begin
			mag_c = 20'sd524287;
		end else if (rnd < -24'sd524288) begin
			mag_c = -20'sd524288;
		end else begin
			mag_c = 20'(rnd);
		end
		if (sb[26].status == ST_AMP || sb[26].status == ST_REGION) begin
			mag_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= sb[26].valid;
		end
	end

	always_ff @(posedge clk) begin
		magnitude_q <= mag_c;
		status_q    <= sb[26].status;
		keep_q      <= sb[26].keep;
	end

	assign done      = done_q;
	assign magnitude = magnitude_q;
	assign status    = status_q;
	assign keep_flag = keep_q;

	`RLM_ASSERT_IMP(a_done_lat, clk, arst_n, done, $past(accept, LATENCY), "result without transfer")
	`RLM_ASSERT_IMP(a_keep, clk, arst_n, done, keep_flag == (status == ST_SNR), "keep flag mismatch")
	`RLM_ASSERT_IMP(a_rej_zero, clk, arst_n, done && (status == ST_AMP || status == ST_REGION), magnitude == 20'sd0, "rejected item carries value")
	`RLM_ASSERT_NXT(a_cfg, clk, arst_n, cfg_we, min_snr_q == $past(cfg_wdata), "min_snr not written")
endmodule
